FILE: hw/rtl/bmpc_pkg.sv
// Shared types, mode codes and constant tables for the blend-mode compositor.
package bmpc_pkg;

    localparam logic [3:0] MODE_NORMAL   = 4'd0;
    localparam logic [3:0] MODE_MULTIPLY = 4'd1;
    localparam logic [3:0] MODE_SCREEN   = 4'd2;
    localparam logic [3:0] MODE_OVERLAY  = 4'd3;
    localparam logic [3:0] MODE_SOFT     = 4'd4;
    localparam logic [3:0] MODE_HARD     = 4'd5;
    localparam logic [3:0] MODE_DARKEN   = 4'd6;
    localparam logic [3:0] MODE_LIGHTEN  = 4'd7;
    localparam logic [3:0] MODE_DODGE    = 4'd8;
    localparam logic [3:0] MODE_BURN     = 4'd9;
    localparam logic [3:0] MODE_LDODGE   = 4'd10;
    localparam logic [3:0] MODE_LBURN    = 4'd11;
    localparam logic [3:0] MODE_DIFF     = 4'd12;
    localparam logic [3:0] MODE_EXCL     = 4'd13;

    localparam int NUM_STAGES = 8;

    typedef logic [16:0] t_dd_tab [256];
    typedef logic [24:0] t_rcp_tab [256];

    typedef struct packed {
        logic [7:0]  da;
        logic [7:0]  sa;
        logic [31:0] dst;
    } t_side;

    // floor(y / 255) for y below 2^24, by reciprocal multiply
    function automatic logic [16:0] f_div255(input logic [23:0] y);
        logic [48:0] p;
        p = {25'd0, y} * 49'd16843010;
        return p[48:32];
    endfunction

    // Q16 soft-light curve: cubic below 64, sqrt(D/255) above
    function automatic t_dd_tab f_build_dd();
        t_dd_tab tab;
        longint signed   p;
        longint unsigned x;
        longint unsigned root;
        longint unsigned bitv;
        for (int i = 0; i < 256; i++) begin
            if (i <= 63) begin
                p = ((16 * longint'(i) - 3060) * longint'(i) + 260100) * longint'(i);
                if (p < 0) p = 0;
                tab[i] = 17'((longint'(p) * 65536) / 16581375);
            end else begin
                x = (longint'(i) << 32) / 255;
                root = 0;
                bitv = 64'd1 << 62;
                while (bitv > x) bitv = bitv >> 2;
                while (bitv != 0) begin
                    if (x >= root + bitv) begin
                        x = x - (root + bitv);
                        root = (root >> 1) + bitv;
                    end else begin
                        root = root >> 1;
                    end
                    bitv = bitv >> 2;
                end
                tab[i] = 17'(root);
            end
        end
        return tab;
    endfunction

    // floor(2^24 / k) by restoring long division; entry 0 is never used
    function automatic t_rcp_tab f_build_rcp();
        t_rcp_tab    tab;
        logic [24:0] q;
        logic [24:0] r;
        tab[0] = '0;
        for (int k = 1; k < 256; k++) begin
            q = '0;
            r = '0;
            for (int b = 24; b >= 0; b--) begin
                r = {r[23:0], (b == 24)};
                q = {q[23:0], 1'b0};
                if (r >= 25'(k)) begin
                    r = r - 25'(k);
                    q[0] = 1'b1;
                end
            end
            tab[k] = q;
        end
        return tab;
    endfunction

    localparam t_dd_tab  DD_TAB  = f_build_dd();
    localparam t_rcp_tab RCP_TAB = f_build_rcp();

endpackage

FILE: hw/rtl/bmpc_mode.sv
// Per-channel blend-mode evaluation, pipeline stages 1 to 4.
module bmpc_mode
    import bmpc_pkg::*;
(
    input  logic       i_clk,
    input  logic [3:0] i_en,
    input  logic [3:0] i_mode,
    input  logic [7:0] i_d,
    input  logic [7:0] i_s,
    output logic [7:0] o_res,
    output logic [7:0] o_d,
    output logic [7:0] o_s
);

    // stage 1
    logic [15:0]        r1_pa;
    logic               r1_hlow;
    logic [15:0]        r1_n;
    logic [7:0]         r1_k;
    logic               r1_kzero;
    logic [15:0]        r1_q0;
    logic [15:0]        r1_t1;
    logic [7:0]         r1_f;
    logic signed [26:0] r1_e;
    logic               r1_lo;
    logic [7:0]         r1_simple;
    logic [7:0]         r1_d;
    logic [7:0]         r1_s;

    logic [7:0]         hx, hy, opa, opb;
    logic               hlow;
    logic [15:0]        n_n;
    logic [7:0]         n_k;
    logic [40:0]        dvp;
    logic [16:0]        dd;
    logic [8:0]         sum9;
    logic [7:0]         n_simple;

    always_comb begin
        if (i_mode == MODE_OVERLAY) begin
            hx = i_s;
            hy = i_d;
        end else begin
            hx = i_d;
            hy = i_s;
        end
        hlow = !hy[7];
        case (i_mode)
            MODE_SCREEN: begin
                opa = ~i_d;
                opb = ~i_s;
            end
            MODE_OVERLAY, MODE_HARD: begin
                opa = hlow ? hx : ~hx;
                opb = hlow ? hy : ~hy;
            end
            default: begin
                opa = i_d;
                opb = i_s;
            end
        endcase
        if (i_mode == MODE_BURN) begin
            n_n = {~i_d, 8'd0} - {8'd0, ~i_d};
            n_k = i_s;
        end else begin
            n_n = {i_d, 8'd0} - {8'd0, i_d};
            n_k = ~i_s;
        end
        dvp = {25'd0, n_n} * {16'd0, RCP_TAB[n_k]};
        dd = DD_TAB[i_d];
        sum9 = {1'b0, i_d} + {1'b0, i_s};
        case (i_mode)
            MODE_DARKEN:  n_simple = (i_d < i_s) ? i_d : i_s;
            MODE_LIGHTEN: n_simple = (i_d > i_s) ? i_d : i_s;
            MODE_LDODGE:  n_simple = sum9[8] ? 8'd255 : sum9[7:0];
            MODE_LBURN:   n_simple = (sum9 < 9'd255) ? 8'd0 : 8'(sum9 - 9'd255);
            MODE_DIFF:    n_simple = (i_d > i_s) ? (i_d - i_s) : (i_s - i_d);
            default:      n_simple = i_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_pa     <= opa * opb;
            r1_hlow   <= hlow;
            r1_n      <= n_n;
            r1_k      <= n_k;
            r1_kzero  <= (n_k == 8'd0);
            r1_q0     <= dvp[39:24];
            r1_t1     <= (8'd255 - {i_s[6:0], 1'b0}) * i_d;
            r1_f      <= {i_s[6:0], 1'b1};
            r1_e      <= $signed({2'b0, dd, 8'd0}) - $signed({10'd0, dd})
                         - $signed({3'd0, i_d, 16'd0});
            r1_lo     <= !i_s[7];
            r1_simple <= n_simple;
            r1_d      <= i_d;
            r1_s      <= i_s;
        end
    end

    // stage 2
    logic [8:0]         r2_qa;
    logic               r2_hlow;
    logic [15:0]        r2_q0;
    logic [16:0]        r2_rem;
    logic [7:0]         r2_k;
    logic               r2_kzero;
    logic [23:0]        r2_t;
    logic signed [36:0] r2_m;
    logic               r2_lo;
    logic [7:0]         r2_simple;
    logic [7:0]         r2_d;
    logic [7:0]         r2_s;

    logic [16:0]        ya;
    logic [16:0]        qa_full;
    logic [23:0]        qk;
    logic [31:0]        d255;
    logic signed [35:0] fe;

    always_comb begin
        if (i_mode == MODE_HARD || i_mode == MODE_OVERLAY || i_mode == MODE_EXCL) begin
            ya = {r1_pa, 1'b0} + 17'd127;
        end else begin
            ya = {1'b0, r1_pa} + 17'd127;
        end
        qa_full = f_div255({7'd0, ya});
        qk   = r1_q0 * r1_k;
        d255 = {({r1_d, 8'd0} - {8'd0, r1_d}), 16'd0};
        fe   = $signed({1'b0, r1_f}) * r1_e;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_qa     <= qa_full[8:0];
            r2_hlow   <= r1_hlow;
            r2_q0     <= r1_q0;
            r2_rem    <= 17'({8'd0, r1_n} - qk);
            r2_k      <= r1_k;
            r2_kzero  <= r1_kzero;
            r2_t      <= r1_t1 * (8'd255 - r1_d);
            r2_m      <= $signed({5'd0, d255}) + 37'(fe);
            r2_lo     <= r1_lo;
            r2_simple <= r1_simple;
            r2_d      <= r1_d;
            r2_s      <= r1_s;
        end
    end

    // stage 3
    logic [7:0]  r3_res;
    logic [16:0] r3_u;
    logic        r3_lo;
    logic [7:0]  r3_d;
    logic [7:0]  r3_s;

    logic [16:0]        qdiv;
    logic [8:0]         exs;
    logic signed [36:0] mv;
    logic [23:0]        u_in;
    logic [7:0]         n_res3;

    always_comb begin
        qdiv = {1'b0, r2_q0} + ((r2_rem >= {9'd0, r2_k}) ? 17'd1 : 17'd0);
        exs  = {1'b0, r2_d} + {1'b0, r2_s} - r2_qa;
        mv   = r2_m + 37'sd8355840;
        if (r2_lo) begin
            u_in = r2_t + 24'd32512;
        end else if (r2_m < 0) begin
            u_in = '0;
        end else begin
            u_in = {3'd0, mv[36:16]};
        end
        case (i_mode)
            MODE_MULTIPLY: n_res3 = r2_qa[7:0];
            MODE_SCREEN:   n_res3 = 8'd255 - r2_qa[7:0];
            MODE_OVERLAY, MODE_HARD:
                n_res3 = r2_hlow ? r2_qa[7:0] : (8'd255 - r2_qa[7:0]);
            MODE_EXCL:     n_res3 = exs[7:0];
            MODE_DODGE: begin
                if (r2_kzero || qdiv > 17'd255) n_res3 = 8'd255;
                else n_res3 = qdiv[7:0];
            end
            MODE_BURN: begin
                if (r2_kzero || qdiv > 17'd255) n_res3 = 8'd0;
                else n_res3 = 8'd255 - qdiv[7:0];
            end
            default:       n_res3 = r2_simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_res <= n_res3;
            r3_u   <= f_div255(u_in);
            r3_lo  <= r2_lo;
            r3_d   <= r2_d;
            r3_s   <= r2_s;
        end
    end

    // stage 4: soft light finishes here
    logic [7:0] r4_res;
    logic [7:0] r4_d;
    logic [7:0] r4_s;

    logic [16:0] w;
    logic [7:0]  n_res4;

    always_comb begin
        w = f_div255({7'd0, r3_u});
        if (i_mode != MODE_SOFT) begin
            n_res4 = r3_res;
        end else if (r3_lo) begin
            n_res4 = r3_d - w[7:0];
        end else begin
            n_res4 = (r3_u > 17'd255) ? 8'd255 : r3_u[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_res <= n_res4;
            r4_d   <= r3_d;
            r4_s   <= r3_s;
        end
    end

    assign o_res = r4_res;
    assign o_d   = r4_d;
    assign o_s   = r4_s;

endmodule

FILE: hw/rtl/bmpc_mix.sv
// Per-channel destination-alpha mix and source-over, pipeline stages 5 to 8.
module bmpc_mix
    import bmpc_pkg::*;
(
    input  logic       i_clk,
    input  logic [3:0] i_en,
    input  logic [3:0] i_mode,
    input  logic [7:0] i_res,
    input  logic [7:0] i_d,
    input  logic [7:0] i_s,
    input  logic [7:0] i_da,
    input  logic [7:0] i_sa,
    output logic [7:0] o_c
);

    logic [15:0] r5_y;
    logic [7:0]  r5_d;
    logic [7:0]  r6_bc;
    logic [7:0]  r6_d;
    logic [15:0] r7_y;
    logic [7:0]  r8_c;

    logic        use_mode;
    logic [15:0] n_y5;
    logic [15:0] n_y7;
    logic [16:0] q6;
    logic [16:0] q8;

    always_comb begin
        use_mode = (i_mode != MODE_NORMAL) && (i_da != 8'd0);
        // s*255 + 127 divides back to s exactly
        if (use_mode) begin
            n_y5 = i_res * i_da + i_s * (8'd255 - i_da) + 16'd127;
        end else begin
            n_y5 = {i_s, 8'd0} - {8'd0, i_s} + 16'd127;
        end
        q6   = f_div255({8'd0, r5_y});
        n_y7 = r6_bc * i_sa + r6_d * (8'd255 - i_sa) + 16'd127;
        q8   = f_div255({8'd0, r7_y});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r5_y <= n_y5;
            r5_d <= i_d;
        end
        if (i_en[1]) begin
            r6_bc <= q6[7:0];
            r6_d  <= r5_d;
        end
        if (i_en[2]) begin
            r7_y <= n_y7;
        end
        if (i_en[3]) begin
            r8_c <= q8[7:0];
        end
    end

    assign o_c = r8_c;

endmodule

FILE: hw/rtl/blend_mode_pixel_compositor_unit.sv
// Blend-mode pixel compositor: top level with handshake, config and alpha path.
// Pipeline: eight register stages from input accept to output valid.
// Throughput: one pixel per cycle; each stage has its own multipliers and advances
// independently, so a stall at the output only holds the stages that are full.
// Reset: synchronous active-low; clears all valid bits and sets blend_mode to normal.
module blend_mode_pixel_compositor_unit
    import bmpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_blend_mode,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_dst_argb,
    input  logic [31:0] i_src_argb,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_argb
);

    logic [3:0]  r_mode;
    logic [NUM_STAGES:1]   r_vld;
    logic [NUM_STAGES+1:1] w_en;
    t_side       r_side [1:NUM_STAGES];
    t_side       w_side [0:NUM_STAGES];
    logic [15:0] r_ya7;
    logic [7:0]  r_oa8;
    logic [16:0] qa8;

    logic [7:0] m_res [3];
    logic [7:0] m_d   [3];
    logic [7:0] m_s   [3];
    logic [7:0] c_out [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (i_cfg_valid) begin
            r_mode <= i_blend_mode;
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_en[NUM_STAGES+1] = i_out_ready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_vld[NUM_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        w_side[0].da  = i_dst_argb[31:24];
        w_side[0].sa  = i_src_argb[31:24];
        w_side[0].dst = i_dst_argb;
        for (int k = 1; k <= NUM_STAGES; k++) begin
            w_side[k] = r_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_side[k] <= w_side[k-1];
            end
        end
    end

    // output alpha: sa + da*(255-sa)/255, rounded
    assign qa8 = f_div255({8'd0, r_ya7});

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_ya7 <= w_side[6].da * (8'd255 - w_side[6].sa) + 16'd127;
        end
        if (w_en[8]) begin
            r_oa8 <= w_side[7].sa + qa8[7:0];
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        bmpc_mode u_mode (
            .i_clk  (i_clk),
            .i_en   (w_en[4:1]),
            .i_mode (r_mode),
            .i_d    (i_dst_argb[23-8*c -: 8]),
            .i_s    (i_src_argb[23-8*c -: 8]),
            .o_res  (m_res[c]),
            .o_d    (m_d[c]),
            .o_s    (m_s[c])
        );

        bmpc_mix u_mix (
            .i_clk  (i_clk),
            .i_en   (w_en[8:5]),
            .i_mode (r_mode),
            .i_res  (m_res[c]),
            .i_d    (m_d[c]),
            .i_s    (m_s[c]),
            .i_da   (w_side[4].da),
            .i_sa   (w_side[6].sa),
            .o_c    (c_out[c])
        );
    end

    // transparent source passes the destination through
    assign o_out_argb = (r_side[NUM_STAGES].sa == 8'd0) ? r_side[NUM_STAGES].dst
                      : {r_oa8, c_out[0], c_out[1], c_out[2]};

endmodule

FILE: dv/tb_blend_mode_pixel_compositor_unit.sv
// Self-checking testbench for the blend-mode pixel compositor unit.
`timescale 1ns / 1ps

class pixel_scoreboard;
    logic [31:0] pending_pixels[$];
    int          n_errors;

    function void note_input(logic [31:0] expected);
        pending_pixels.push_back(expected);
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    task check_output(logic [31:0] actual);
        logic [31:0] want;
        if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel %h", actual));
        end else begin
            want = pending_pixels.pop_front();
            if (want !== actual) begin
                report($sformatf("out_argb %h, expected %h", actual, want));
            end
        end
    endtask
endclass

module tb_blend_mode_pixel_compositor_unit
    import bmpc_pkg::*;
();

    localparam int MAX_CYCLES = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_blend_mode = MODE_NORMAL;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_dst_argb = '0;
    logic [31:0] i_src_argb = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_out_argb;

    pixel_scoreboard sb = new();
    logic [3:0]      cur_mode;
    int              cycle_count = 0;
    bit              hold_sink;

    always #10 i_clk = ~i_clk;

    blend_mode_pixel_compositor_unit dut (.*);

    function automatic int div255r(int x);
        return (x + 127) / 255;
    endfunction

    function automatic int clamp8(longint v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return int'(v);
    endfunction

    function automatic longint isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic int soft_light(int d, int s);
        longint dl, sl, n, dd, p, m;
        dl = d;
        sl = s;
        if (s <= 127) begin
            n = dl * 65025 - (255 - 2 * sl) * dl * (255 - dl);
            if (n < 0) return 0;
            return clamp8((2 * n + 65025) / 130050);
        end
        if (d <= 63) begin
            p = ((16 * dl - 3060) * dl + 260100) * dl;
            if (p < 0) p = 0;
            dd = (p * 65536) / 16581375;
        end else begin
            dd = isqrt((longint'(d) << 32) / 255);
        end
        m = dl * 255 * 65536 + (2 * sl - 255) * (255 * dd - 65536 * dl);
        if (m < 0) return 0;
        return clamp8((2 * m + 255 * 65536) / (2 * 255 * 65536));
    endfunction

    function automatic int hard_light(int d, int s);
        if (s <= 127) return div255r(d * 2 * s);
        return 255 - div255r((255 - d) * (2 * (255 - s)));
    endfunction

    function automatic int blend_channel(logic [3:0] mode, int d, int s);
        case (mode)
            MODE_MULTIPLY: return div255r(d * s);
            MODE_SCREEN:   return 255 - div255r((255 - d) * (255 - s));
            MODE_OVERLAY:  return hard_light(s, d);
            MODE_SOFT:     return soft_light(d, s);
            MODE_HARD:     return hard_light(d, s);
            MODE_DARKEN:   return d < s ? d : s;
            MODE_LIGHTEN:  return d > s ? d : s;
            MODE_DODGE:    return s >= 255 ? 255 : clamp8((d * 255) / (255 - s));
            MODE_BURN:     return s <= 0 ? 0 : clamp8(255 - ((255 - d) * 255) / s);
            MODE_LDODGE:   return clamp8(d + s);
            MODE_LBURN:    return clamp8(d + s - 255);
            MODE_DIFF:     return d > s ? d - s : s - d;
            MODE_EXCL:     return d + s - div255r(2 * d * s);
            default:       return s;
        endcase
    endfunction

    function automatic logic [31:0] composite_pixel(logic [3:0] mode, logic [31:0] dst,
                                                    logic [31:0] src);
        int sa, da, sc, dc, bc, inv, oa;
        logic [31:0] res;
        sa = src[31:24];
        da = dst[31:24];
        if (sa == 0) return dst;
        inv = 255 - sa;
        oa = sa + div255r(da * inv);
        res = (sa == 255) ? 32'hFF000000 : {oa[7:0], 24'd0};
        for (int i = 0; i < 3; i++) begin
            sc = src[16 - 8 * i +: 8];
            dc = dst[16 - 8 * i +: 8];
            bc = sc;
            if (mode != MODE_NORMAL && da > 0)
                bc = div255r(blend_channel(mode, dc, sc) * da + sc * (255 - da));
            if (sa != 255) bc = div255r(bc * sa + dc * inv);
            res[16 - 8 * i +: 8] = bc[7:0];
        end
        return res;
    endfunction

    task automatic write_mode(logic [3:0] mode);
        @(negedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_blend_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_mode = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [31:0] dst, logic [31:0] src, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_dst_argb <= dst;
        i_src_argb <= src;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(composite_pixel(cur_mode, dst, src));
        @(negedge i_clk);
    endtask

    task automatic finish_burst();
        i_in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (NUM_STAGES + 4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_pixel();
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    // output side: random back-pressure, plus one long hold-off
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_out_ready <= 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_output(o_out_argb);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("** blend_mode_pixel_compositor_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int busy;
        hold_sink = 1'b0;
        cur_mode = MODE_NORMAL;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every mode across the extremes and special cases
        for (int m = 0; m < 16; m++) begin
            write_mode(m[3:0]);
            send_pixel(32'hFFFFFFFF, 32'h00123456, 1'b0);
            send_pixel(32'h00FF00FF, 32'hFF00FF80, 1'b0);
            send_pixel(32'hFF20E080, 32'hFFFF0080, 1'b1);
            send_pixel(32'h80407FC0, 32'h7F80FF00, 1'b1);
            send_pixel(32'h00000000, 32'h01FFFFFF, 1'b0);
            finish_burst();
        end

        // long receiver hold-off while the input keeps offering
        write_mode(MODE_SOFT);
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            for (int k = 0; k < 40; k++) send_pixel(pick_pixel(), pick_pixel(), 1'b1);
        join
        finish_burst();

        for (int ph = 0; ph < 16; ph++) begin
            busy = (ph < 2) ? 13 : $urandom_range(0, 15);
            write_mode((ph == 0) ? MODE_NORMAL : busy[3:0]);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 1))
                    send_pixel($urandom, $urandom, $urandom_range(0, 2) != 0);
                else
                    send_pixel(pick_pixel(), pick_pixel(), $urandom_range(0, 2) != 0);
            end
            finish_burst();
        end

        if (sb.n_errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("** blend_mode_pixel_compositor_unit: PASSED **");
        end else begin
            $display("** blend_mode_pixel_compositor_unit: FAILED **");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/bmpc_pkg.sv
hw/rtl/bmpc_mode.sv
hw/rtl/bmpc_mix.sv
hw/rtl/blend_mode_pixel_compositor_unit.sv
dv/tb_blend_mode_pixel_compositor_unit.sv
